[sv/varint_mutation_record_packer_core_defines.svh]
// ----------------------------------------------------------------------------
// varint mutation record packer defines
// assertion macros of the packer rtl
// ----------------------------------------------------------------------------
`ifndef VARINT_MUTATION_RECORD_PACKER_CORE_DEFINES_SVH
`define VARINT_MUTATION_RECORD_PACKER_CORE_DEFINES_SVH

// condition must hold at every rising clock edge outside reset
`define VMRP_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define VMRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/vmrp_pkg.sv]
// ----------------------------------------------------------------------------
// vmrp_pkg
// types and constants of the varint mutation record packer
// ----------------------------------------------------------------------------
package vmrp_pkg;

   localparam int FIELD_BITS     = 32;
   localparam int DEF_VALUE_BITS = 32;
   localparam int DIGIT_BITS     = 7;
   localparam int NIBBLE_BITS    = 4;
   localparam int BYTE_BITS      = 8;

   typedef enum logic [1:0] {
      OP_NAME  = 2'd0,
      OP_COUNT = 2'd1,
      OP_MUT   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [BYTE_BITS-1:0]    name_byte;
      logic [FIELD_BITS-1:0]   mut_count;
      logic [FIELD_BITS-1:0]   position;
      logic [NIBBLE_BITS-1:0]  allele_code;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 run_last;
      logic                 record_done;
   } rsp_type;

   // control into the digit shifter
   typedef struct packed {
      logic load;
      logic shift;
   } dig_ctl_type;

   // status out of the digit shifter
   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic                  more;
   } dig_sts_type;

endpackage

[sv/vmrp_digit_shift.sv]
// ----------------------------------------------------------------------------
// vmrp_digit_shift
// value shift register that hands out one base-128 digit per shift
// ----------------------------------------------------------------------------
module vmrp_digit_shift
   import vmrp_pkg::*;
#(
   parameter int WIDTH = DEF_VALUE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  dig_ctl_type      ctl,
   input  logic [WIDTH-1:0] load_value,
   output dig_sts_type      sts
);

   logic [WIDTH-1:0] val_ff;
   logic [WIDTH-1:0] val_in;
   logic [WIDTH-1:0] rest;

   assign rest       = val_ff >> DIGIT_BITS;
   assign sts.digit  = val_ff[DIGIT_BITS-1:0];
   assign sts.more   = (rest != '0);

   always_comb begin
      val_in = val_ff;
      if (ctl.load) begin
         val_in = load_value;
      end else if (ctl.shift) begin
         val_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

endmodule

[sv/vmrp_out_reg.sv]
// ----------------------------------------------------------------------------
// vmrp_out_reg
// output register of the result channel
// ----------------------------------------------------------------------------
module vmrp_out_reg
   import vmrp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_item,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_item;
      end
   end

endmodule

[sv/varint_mutation_record_packer_core.sv]
// ----------------------------------------------------------------------------
// varint_mutation_record_packer_core
// packs one sample record: name bytes, varint count, varint positions and
// paired nibble code bytes
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_data  (req_type)
//   rsp       out         rsp_valid/rsp_ready    rsp_data  (rsp_type)
//
// a name byte is one output item; a count gives an n-byte varint
// (1 to 5 bytes); a mutation gives a position varint, plus a code byte if due
// the varint leaves the digit shifter 7 bits per cycle, one output byte each,
// unless rsp stalls; a dropped mutation or an undefined op gives no item
// reset is synchronous and clears the sequencer, counters and output valid
// a stalled rsp holds the sequencer; req is taken only from idle with room
//
`include "varint_mutation_record_packer_core_defines.svh"

module varint_mutation_record_packer_core
   import vmrp_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // width actually carried by the shifter
   localparam int EFF_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam logic [FIELD_BITS-1:0] VALUE_MASK = (VALUE_BITS >= FIELD_BITS) ? '1 :
      FIELD_BITS'((64'(1) << VALUE_BITS) - 64'(1));

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_VARINT = 3'b010,
      S_CODE   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // record state
   logic [FIELD_BITS-1:0]  remaining_ff, remaining_in;
   logic                   half_pending_ff, half_pending_in;
   logic [NIBBLE_BITS-1:0] held_code_ff, held_code_in;

   // per item context
   logic [BYTE_BITS-1:0]   code_byte_ff, code_byte_in;
   logic                   need_code_ff, need_code_in;
   logic                   final_done_ff, final_done_in;

   logic [FIELD_BITS-1:0]  cnt_masked;
   logic [FIELD_BITS-1:0]  pos_masked;
   logic [EFF_BITS-1:0]    load_value;
   dig_ctl_type            dig_ctl;
   dig_sts_type            dig_sts;
   logic                   out_load;
   logic                   out_free;
   rsp_type                out_item;
   logic                   req_take;

   assign cnt_masked = req_data.mut_count & VALUE_MASK;
   assign pos_masked = req_data.position & VALUE_MASK;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign req_take   = req_valid && req_ready;

   vmrp_digit_shift #(
      .WIDTH(EFF_BITS)
   ) u_digit_shift (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dig_ctl),
      .load_value(load_value),
      .sts       (dig_sts)
   );

   vmrp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .load_item(out_item),
      .free     (out_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always_comb begin
      state_in        = state_ff;
      remaining_in    = remaining_ff;
      half_pending_in = half_pending_ff;
      held_code_in    = held_code_ff;
      code_byte_in    = code_byte_ff;
      need_code_in    = need_code_ff;
      final_done_in   = final_done_ff;
      dig_ctl         = '0;
      load_value      = '0;
      out_load        = 1'b0;
      out_item        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req_data.op)
                  OP_NAME: begin
                     // name bytes pass straight through, state untouched
                     out_load             = 1'b1;
                     out_item.out_byte    = req_data.name_byte;
                     out_item.run_last    = 1'b1;
                     out_item.record_done = 1'b0;
                  end
                  OP_COUNT: begin
                     dig_ctl.load    = 1'b1;
                     load_value      = cnt_masked[EFF_BITS-1:0];
                     remaining_in    = cnt_masked;
                     half_pending_in = 1'b0;
                     held_code_in    = '0;
                     need_code_in    = 1'b0;
                     final_done_in   = (cnt_masked == '0);
                     state_in        = S_VARINT;
                  end
                  OP_MUT: begin
                     // nothing remaining: dropped without an item
                     if (remaining_ff != '0) begin
                        dig_ctl.load = 1'b1;
                        load_value   = pos_masked[EFF_BITS-1:0];
                        remaining_in = remaining_ff - FIELD_BITS'(1);
                        if (half_pending_ff) begin
                           // second of a pair closes the code byte
                           code_byte_in    = {req_data.allele_code, held_code_ff};
                           need_code_in    = 1'b1;
                           final_done_in   = (remaining_ff == FIELD_BITS'(1));
                           half_pending_in = 1'b0;
                           held_code_in    = '0;
                        end else if (remaining_ff == FIELD_BITS'(1)) begin
                           // odd last mutation gets a code byte of its own
                           code_byte_in  = {{NIBBLE_BITS{1'b0}}, req_data.allele_code};
                           need_code_in  = 1'b1;
                           final_done_in = 1'b1;
                        end else begin
                           half_pending_in = 1'b1;
                           held_code_in    = req_data.allele_code;
                           need_code_in    = 1'b0;
                           final_done_in   = 1'b0;
                        end
                        state_in = S_VARINT;
                     end
                  end
                  default: begin
                     // undefined op is ignored
                  end
               endcase
            end
         end
         S_VARINT: begin
            if (out_free) begin
               dig_ctl.shift     = 1'b1;
               out_load          = 1'b1;
               out_item.out_byte = {dig_sts.more, dig_sts.digit};
               if (!dig_sts.more) begin
                  if (need_code_ff) begin
                     state_in = S_CODE;
                  end else begin
                     out_item.run_last    = 1'b1;
                     out_item.record_done = final_done_ff;
                     state_in             = S_IDLE;
                  end
               end
            end
         end
         S_CODE: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_item.out_byte    = code_byte_ff;
               out_item.run_last    = 1'b1;
               out_item.record_done = final_done_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         remaining_ff    <= '0;
         half_pending_ff <= 1'b0;
         held_code_ff    <= '0;
         need_code_ff    <= 1'b0;
         final_done_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         remaining_ff    <= remaining_in;
         half_pending_ff <= half_pending_in;
         held_code_ff    <= held_code_in;
         need_code_ff    <= need_code_in;
         final_done_ff   <= final_done_in;
      end
   end

   // code byte needs no reset
   always_ff @(posedge clock) begin
      code_byte_ff <= code_byte_in;
   end

   // a pending half pair always has a mutation still to come
   `VMRP_ASSERT_IMPLY(a_half_has_remaining, half_pending_ff, remaining_ff != '0,
      "half pair pending with nothing remaining")
   // the output register is never overwritten while it still holds an item
   `VMRP_ASSERT_IMPLY(a_load_when_free, out_load, out_free,
      "output register loaded while full")
   // record completion only ever marks the last byte of an item
   `VMRP_ASSERT_IMPLY(a_done_is_last, rsp_valid && rsp_data.record_done,
      rsp_data.run_last, "record done without run last")
   // the pair is settled before the code byte goes out
   `VMRP_ASSERT_IMPLY(a_code_clears_half, state_ff == S_CODE, !half_pending_ff,
      "half pair still pending in code byte state")

endmodule

[verif/vmrp_record_check_pkg.sv]
// ----------------------------------------------------------------------------
// vmrp_record_check_pkg
// predicts the serialized record bytes of the packer and checks the rsp stream
// ----------------------------------------------------------------------------
package vmrp_record_check_pkg;

   import vmrp_pkg::*;

   localparam int VALUE_BITS = DEF_VALUE_BITS;

   class record_byte_checker;

      // packer state as the predictor sees it
      logic [FIELD_BITS-1:0]  remaining;
      logic                   half_pending;
      logic [NIBBLE_BITS-1:0] held_code;

      rsp_type     expected_bytes[$];
      int unsigned error_count;
      int unsigned byte_count;
      int unsigned record_count;

      function new();
         remaining    = '0;
         half_pending = 1'b0;
         held_code    = '0;
         error_count  = 0;
         byte_count   = 0;
         record_count = 0;
      endfunction

      function logic [63:0] value_mask();
         if (VALUE_BITS >= 64) begin
            return '1;
         end
         return (64'd1 << VALUE_BITS) - 64'd1;
      endfunction

      function void push_byte(logic [BYTE_BITS-1:0] value);
         rsp_type entry;
         entry.out_byte    = value;
         entry.run_last    = 1'b0;
         entry.record_done = 1'b0;
         expected_bytes.insert(expected_bytes.size(), entry);
      endfunction

      // little-endian base-128, continuation bit on all but the last byte
      function void push_varint(logic [63:0] value);
         logic [63:0]          rest;
         logic [BYTE_BITS-1:0] digit;
         rest = value;
         do begin
            digit = {1'b0, rest[DIGIT_BITS-1:0]};
            rest  = rest >> DIGIT_BITS;
            if (rest != 0) begin
               digit[BYTE_BITS-1] = 1'b1;
            end
            push_byte(digit);
         end while (rest != 0);
      endfunction

      // tag the newest byte as the end of this item's run
      function void close_run(logic done);
         expected_bytes[expected_bytes.size()-1].run_last    = 1'b1;
         expected_bytes[expected_bytes.size()-1].record_done = done;
      endfunction

      // returns how many bytes the accepted item will produce
      function int note_request(req_type item);
         int          start_size;
         logic [63:0] masked;
         start_size = expected_bytes.size();
         unique case (item.op)
            OP_NAME: begin
               push_byte(item.name_byte);
               close_run(1'b0);
            end
            OP_COUNT: begin
               masked       = {32'd0, item.mut_count} & value_mask();
               remaining    = masked[FIELD_BITS-1:0];
               half_pending = 1'b0;
               held_code    = '0;
               push_varint(masked);
               close_run(remaining == 0);
            end
            OP_MUT: begin
               if (remaining != 0) begin
                  push_varint({32'd0, item.position} & value_mask());
                  remaining = remaining - 1;
                  if (half_pending) begin
                     push_byte({item.allele_code, held_code});
                     half_pending = 1'b0;
                     held_code    = '0;
                     close_run(remaining == 0);
                  end else if (remaining == 0) begin
                     push_byte({4'd0, item.allele_code});
                     close_run(1'b1);
                  end else begin
                     half_pending = 1'b1;
                     held_code    = item.allele_code;
                     close_run(1'b0);
                  end
               end
            end
            default: begin
            end
         endcase
         return expected_bytes.size() - start_size;
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("out_byte: expected nothing, got 0x%02h", got.out_byte);
            error_count++;
            return;
         end
         want = expected_bytes.pop_front();
         byte_count++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
            error_count++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, got.run_last);
            error_count++;
         end
         if (got.record_done !== want.record_done) begin
            $error("record_done: expected %b, got %b", want.record_done, got.record_done);
            error_count++;
         end
         if (want.record_done) begin
            record_count++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

   endclass

endpackage

[verif/tb_varint_mutation_record_packer_core.sv]
// ----------------------------------------------------------------------------
// tb_varint_mutation_record_packer_core
// drives name, count and mutation items into the record packer with random
// gaps and rsp stalls, and checks every output byte and its run/record flags
// ----------------------------------------------------------------------------
module tb_varint_mutation_record_packer_core;

   timeunit 1ns;
   timeprecision 1ps;

   import vmrp_pkg::*;
   import vmrp_record_check_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 480;
   localparam int TAIL_CYCLES  = 24;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   record_byte_checker tracker;

   // when set, neither side inserts gaps
   bit steady = 1'b1;

   int byte_items   = 0;   // items that produced bytes
   int quiet_items  = 0;   // dropped mutations and undefined ops
   int stall_left   = 0;
   int cycle_count  = 0;

   varint_mutation_record_packer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_type random_fields(op_type op);
      req_type item;
      item.op          = op;
      item.name_byte   = 8'($urandom);
      item.mut_count   = $urandom;
      item.position    = $urandom;
      item.allele_code = 4'($urandom);
      return item;
   endfunction

   // values spread over every varint length, with the 7-bit boundaries
   function automatic logic [31:0] spread_value();
      logic [31:0] value;
      value = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 9))
            0: value = 32'd0;
            1: value = 32'd127;
            2: value = 32'd128;
            3: value = 32'd16383;
            4: value = 32'd16384;
            5: value = 32'd2097151;
            6: value = 32'd2097152;
            7: value = 32'h0fff_ffff;
            8: value = 32'h1000_0000;
            default: value = 32'hffff_ffff;
         endcase
      end else begin
         value = value >> $urandom_range(0, 31);
      end
      return value;
   endfunction

   // rsp side: ready drops for random stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // every accepted byte goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_byte(rsp_data);
      end
   end

   // hang guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input req_type item);
      int gap;
      int caused;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      caused = tracker.note_request(item);
      if (caused > 0) begin
         byte_items++;
      end else begin
         quiet_items++;
      end
      @(negedge clock);
   endtask

   task automatic send_name(input logic [7:0] value);
      req_type item;
      item           = random_fields(OP_NAME);
      item.name_byte = value;
      send_item(item);
   endtask

   task automatic send_count(input logic [31:0] value);
      req_type item;
      item           = random_fields(OP_COUNT);
      item.mut_count = value;
      send_item(item);
   endtask

   task automatic send_mut(input logic [31:0] pos, input logic [3:0] code);
      req_type item;
      item             = random_fields(OP_MUT);
      item.position    = pos;
      item.allele_code = code;
      send_item(item);
   endtask

   // sender holds off until every predicted byte has come out
   task automatic drain_outputs();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
   endtask

   initial begin
      int name_len;
      int count_kind;
      int mut_total;
      int mut_sent;
      logic [31:0] count_value;

      tracker = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---------------- directed part ----------------
      send_name(8'h00);
      send_name(8'hff);
      send_mut(32'd5, 4'h6);                  // nothing remaining: dropped
      send_item(random_fields(OP_NONE));      // undefined op: ignored
      send_count(32'd0);                      // empty record finishes on the count
      send_count(32'hffff_ffff);              // five-byte varint
      send_count(32'd3);
      send_mut(32'd0, 4'h0);
      send_name(8'h41);                       // name byte in the middle of a record
      send_mut(32'hffff_ffff, 4'hf);          // closes the pair
      send_mut(32'd127, 4'ha);                // odd last mutation, code-only byte
      send_mut(32'd128, 4'h5);                // record is over: dropped
      send_count(32'd2);
      send_mut(32'd16383, 4'h3);
      send_count(32'd4);                      // new count drops the half pair
      send_mut(32'd16384, 4'hc);
      send_mut(32'h0020_0000, 4'h7);
      send_item(random_fields(OP_NONE));
      send_mut(32'h1000_0000, 4'hf);
      send_mut(32'h0fff_ffff, 4'h1);          // pair byte finishes the record
      send_count(32'd1);
      send_mut(32'h8000_0000, 4'h9);
      drain_outputs();

      // ---------------- random records ----------------
      while (byte_items + quiet_items < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // noise: any op, undefined one included, random content
            repeat ($urandom_range(1, 3)) begin
               send_item(random_fields(op_type'($urandom_range(0, 3))));
            end
         end else begin
            name_len = $urandom_range(0, 5);
            repeat (name_len) send_name(8'($urandom_range(1, 255)));
            send_name(8'h00);

            count_kind = $urandom_range(0, 19);
            if (count_kind == 0) begin
               count_value = 32'd0;
               mut_total   = 0;
            end else if (count_kind == 1) begin
               // huge count that a later count cuts short
               count_value = spread_value() | 32'h0000_0100;
               mut_total   = $urandom_range(0, 3);
            end else begin
               count_value = $urandom_range(1, 7);
               mut_total   = count_value;
            end
            // occasionally a broken record: cut short or overrun
            if (mut_total > 0 && $urandom_range(0, 7) == 0) begin
               mut_total = $urandom_range(0, mut_total - 1);
            end else if ($urandom_range(0, 5) == 0) begin
               mut_total = mut_total + 1;
            end
            send_count(count_value);

            for (mut_sent = 0; mut_sent < mut_total; mut_sent++) begin
               if ($urandom_range(0, 15) == 0) begin
                  send_name(8'($urandom));
               end
               send_mut(spread_value(), 4'($urandom));
            end
         end
         if ($urandom_range(0, 11) == 0) begin
            drain_outputs();
         end
      end
      steady = 1'b0;

      // ---------------- wind down ----------------
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d byte-producing items and %0d dropped or ignored items",
               byte_items, quiet_items);
      $display("checked %0d output bytes across %0d finished records",
               tracker.byte_count, tracker.record_count);
      if (tracker.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
